/* hdl/sii_pkg.sv */
`default_nettype none

package sii_pkg;

  typedef struct packed {
    logic [31:0] iv_start;
    logic [31:0] iv_end;
  } interval_t;

  typedef struct packed {
    logic      pop;
    logic      push;
    interval_t wdata;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE,
    ST_DUMP,
    ST_EMPTY
  } state_e;

  localparam logic       MODE_INSERT = 1'b0;
  localparam logic       MODE_CLEAR  = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

endpackage

`default_nettype wire

/* hdl/sii_cell.sv */
`default_nettype none

module sii_cell import sii_pkg::*; #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic [IW-1:0] widx_i,
  input  wire interval_t  next_i,
  output interval_t       data_o
);

  interval_t data_q;

  // Take the tail write when addressed, otherwise advance toward the head on a pop.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (widx_i == IW'(IDX))) begin
      data_q <= ctrl_i.wdata;
    end else if (ctrl_i.pop) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* hdl/sorted_interval_insert_merge_top.sv */
// An insert first rotates the stored list once to count overlaps, then merges it through the head
//   cell into the results, or dumps it unchanged when the store is full and nothing overlaps;
//   a reject dumps the list, a clear sends an empty-list result, and results wait while the output stalls.
// A new item is accepted only in the idle state, after the previous item's last result is loaded;
//   the head cell reads the list out one interval a cycle while the output does not stall.
// Reset (rst_ni low, asynchronous): list empty, controller idle, no result pending.
`default_nettype none

module sorted_interval_insert_merge_top import sii_pkg::*; #(
  parameter int MAX_INTERVALS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [31:0] new_start_i,
  input  wire logic [31:0] new_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_start_o,
  output logic [31:0]      out_end_o,
  output logic [3:0]       out_index_o,
  output logic             entry_valid_o,
  output logic [4:0]       list_count_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  // CW holds a count up to MAX_INTERVALS, IW addresses one cell.
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int IW = $clog2(MAX_INTERVALS);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;      // intervals held in the cell row
  logic [CW-1:0] len_q, len_d;      // list length when the item arrived
  logic [CW-1:0] t_q, t_d;          // step within the current pass
  logic [CW-1:0] ov_q, ov_d;        // stored intervals that overlap the new one
  logic [CW-1:0] k_q, k_d;          // results sent for this item
  logic [CW-1:0] m_q, m_d;          // results this item sends
  logic [1:0]    status_q, status_d;
  interval_t     carry_q, carry_d;  // interval being merged, then held one step once placed
  logic          placed_q, placed_d;

  logic          out_valid_q;
  logic [31:0]   out_start_q, out_end_q;
  logic [3:0]    out_index_q;
  logic          entry_valid_q, last_q;
  logic [4:0]    list_count_q;
  logic [1:0]    out_status_q;

  cell_ctrl_t    ctrl;
  logic [IW-1:0] widx;
  interval_t     cells [MAX_INTERVALS];
  interval_t     head;

  logic          slot_free;
  logic          emit, emit_empty;
  interval_t     emit_iv;
  logic          hit;
  logic [CW-1:0] ov_next;
  logic [CW:0]   m_full;
  logic [CW-1:0] last_k;
  logic [31:0]   k_ext, m_ext;

  assign head      = cells[0];
  assign slot_free = !out_valid_q || out_ready_i;
  assign hit       = (head.iv_start <= carry_q.iv_end) && (head.iv_end >= carry_q.iv_start);
  assign ov_next   = ov_q + CW'(hit);
  assign m_full    = {1'b0, len_q} + (CW+1)'(1) - {1'b0, ov_next};
  assign last_k    = m_q - CW'(1);
  assign k_ext     = 32'(k_q);
  assign m_ext     = 32'(m_q);

  // Row of cells: pop drains toward cell 0, push writes behind the remaining entries.
  assign widx = IW'(cnt_q - CW'(ctrl.pop));

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    interval_t nxt;
    if (i == MAX_INTERVALS - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cells[i+1];
    end
    sii_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .widx_i (widx),
      .next_i (nxt),
      .data_o (cells[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    t_d        = t_q;
    ov_d       = ov_q;
    k_d        = k_q;
    m_d        = m_q;
    status_d   = status_q;
    carry_d    = carry_q;
    placed_d   = placed_q;
    ctrl.pop   = 1'b0;
    ctrl.push  = 1'b0;
    ctrl.wdata = head;
    emit       = 1'b0;
    emit_empty = 1'b0;
    emit_iv    = head;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          t_d      = '0;
          k_d      = '0;
          ov_d     = '0;
          placed_d = 1'b0;
          len_d    = cnt_q;
          carry_d  = '{iv_start: new_start_i, iv_end: new_end_i};
          if (mode_i == MODE_CLEAR) begin
            status_d = STATUS_OK;
            state_d  = ST_EMPTY;
          end else if (new_start_i > new_end_i) begin
            status_d = STATUS_BAD;
            m_d      = cnt_q;
            state_d  = (cnt_q == '0) ? ST_EMPTY : ST_DUMP;
          end else if (cnt_q == '0) begin
            status_d = STATUS_OK;
            m_d      = CW'(1);
            state_d  = ST_MERGE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Rotate the list once and count overlaps.
        ctrl.pop  = 1'b1;
        ctrl.push = 1'b1;
        ov_d      = ov_next;
        t_d       = t_q + CW'(1);
        if (t_q == len_q - CW'(1)) begin
          t_d = '0;
          if ((ov_next == '0) && (len_q == CW'(MAX_INTERVALS))) begin
            status_d = STATUS_FULL;
            m_d      = len_q;
            state_d  = ST_DUMP;
          end else begin
            status_d = STATUS_OK;
            m_d      = m_full[CW-1:0];
            state_d  = ST_MERGE;
          end
        end
      end

      ST_DUMP: begin
        if (slot_free) begin
          ctrl.pop  = 1'b1;
          ctrl.push = 1'b1;
          emit      = 1'b1;
          t_d       = t_q + CW'(1);
          k_d       = k_q + CW'(1);
          if (t_q == len_q - CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_MERGE: begin
        if (slot_free) begin
          if (t_q == len_q) begin
            // Flush the carry: merged interval or the last held entry.
            emit    = 1'b1;
            emit_iv = carry_q;
            state_d = ST_IDLE;
          end else begin
            ctrl.pop = 1'b1;
            if (placed_q) begin
              emit    = 1'b1;
              emit_iv = carry_q;
              carry_d = head;
            end else if (head.iv_end < carry_q.iv_start) begin
              emit    = 1'b1;
              emit_iv = head;
            end else if (head.iv_start > carry_q.iv_end) begin
              emit     = 1'b1;
              emit_iv  = carry_q;
              carry_d  = head;
              placed_d = 1'b1;
            end else begin
              // Absorb the overlapping entry into the carry.
              if (head.iv_start < carry_q.iv_start) begin
                carry_d.iv_start = head.iv_start;
              end
              if (head.iv_end > carry_q.iv_end) begin
                carry_d.iv_end = head.iv_end;
              end
            end
          end
          ctrl.push  = emit;
          ctrl.wdata = emit_iv;
          t_d        = t_q + CW'(1);
          k_d        = k_q + CW'(emit);
        end
      end

      ST_EMPTY: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_empty = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if ((state_q == ST_IDLE) && in_valid_i && (mode_i == MODE_CLEAR)) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q + CW'(ctrl.push) - CW'(ctrl.pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pass bookkeeping and the output register: no reset needed.
  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    t_q      <= t_d;
    ov_q     <= ov_d;
    k_q      <= k_d;
    m_q      <= m_d;
    status_q <= status_d;
    carry_q  <= carry_d;
    placed_q <= placed_d;
    if (emit) begin
      out_status_q <= status_q;
      if (emit_empty) begin
        out_start_q   <= '0;
        out_end_q     <= '0;
        out_index_q   <= '0;
        entry_valid_q <= 1'b0;
        list_count_q  <= '0;
        last_q        <= 1'b1;
      end else begin
        out_start_q   <= emit_iv.iv_start;
        out_end_q     <= emit_iv.iv_end;
        out_index_q   <= k_ext[3:0];
        entry_valid_q <= 1'b1;
        list_count_q  <= m_ext[4:0];
        last_q        <= (k_q == last_k);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_start_o   = out_start_q;
  assign out_end_o     = out_end_q;
  assign out_index_o   = out_index_q;
  assign entry_valid_o = entry_valid_q;
  assign list_count_o  = list_count_q;
  assign status_o      = out_status_q;
  assign last_o        = last_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("result loaded while a previous transfer is pending");

  a_scan_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !emit && (ctrl.pop == ctrl.push))
    else $error("overlap scan must rotate the list without results");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_INTERVALS))
    else $error("cell row over capacity");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !entry_valid_o) |-> (last_o && (list_count_o == 5'd0)))
    else $error("empty-list result must be last with zero count");
`endif

endmodule

`default_nettype wire
